### rtl/spi_cps_pkg.sv
// package: shared types, constants and helpers of the spi clock prescaler select block
package spi_cps_pkg;

	localparam int RATE_WIDTH_DEF = 32;
	localparam int CFG_DATA_W     = 32;
	localparam int SPEED_W        = 32;
	localparam int CLOCK_FIELD_W  = 14;
	localparam int PRESCALE_W     = 4;
	localparam int PRE_DIV_W      = 3;
	localparam int SCLK_DIV_W     = 3;
	localparam int HALVE_CNT_W    = 4;

	localparam int CLOCK_RESET_HZ = 200000000;

	// divider limits
	localparam int PSCL_MAX_X2    = 30;
	localparam int PSCL_MAX       = 15;
	localparam int PRE_DIV_MAX    = 7;
	localparam int SCLK_DIV_MAX   = 4;
	localparam int SCLK_DIV_SHIFT = 11;

	localparam logic [CLOCK_FIELD_W-1:0] X2_BIT = CLOCK_FIELD_W'(16'h0010);

	typedef enum logic [1:0] {
		VAR_EVEN  = 2'd0,
		VAR_CEIL  = 2'd1,
		VAR_FLOOR = 2'd2,
		VAR_SCLK  = 2'd3
	} variant_t;

	typedef enum logic [0:0] {
		REG_INPUT_CLOCK = 1'b0,
		REG_VARIANT     = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_ROUND,
		ST_HALVE,
		ST_FINISH
	} state_t;

	// pre-divider exponent bits 0,1,2 go to field bits 4,6,7
	function automatic logic [CLOCK_FIELD_W-1:0] pre_bits(input logic [PRE_DIV_W-1:0] pdiv);
		logic [CLOCK_FIELD_W-1:0] f;
		f    = '0;
		f[4] = pdiv[0];
		f[6] = pdiv[1];
		f[7] = pdiv[2];
		return f;
	endfunction

endpackage

### rtl/spi_cps_ifs.sv
// interfaces: request channel carrying the rate and result channel carrying the clock settings
interface spi_cps_rate_if
	import spi_cps_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [SPEED_W-1:0] bit_rate;

	modport source (output valid, output bit_rate, input ready);
	modport sink (input valid, input bit_rate, output ready);
endinterface

interface spi_cps_result_if
	import spi_cps_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic [CLOCK_FIELD_W-1:0] clock_field;
	logic [PRESCALE_W-1:0]    prescale;
	logic [PRE_DIV_W-1:0]     pre_divider;
	logic [SCLK_DIV_W-1:0]    sclk_divider;
	logic                     rejected;

	modport source (output valid, output clock_field, output prescale, output pre_divider,
		output sclk_divider, output rejected, input ready);
	modport sink (input valid, input clock_field, input prescale, input pre_divider,
		input sclk_divider, input rejected, output ready);
endinterface

### rtl/spi_clock_prescaler_select.sv
// top level: spi serial clock divider selection from a requested bit rate
//
// rate_in takes one request (bit_rate); result_out returns one result per
// request: the packed clock bits, prescale, pre-divider and sclk divider
// exponents and a rejected flag (all other fields zero when rejected).
// the config port sets the core clock (index 0) and divider scheme (index 1);
// write it only while no request is in flight.
// a request runs through one shared restoring divider, one quotient bit per
// cycle, then one rounding step and one halving per cycle on a shared
// incrementer/shifter; a zero rate skips the divider, rounding and halvings
// and goes straight to the finish step.
// rate_in.ready is high only while the sequencer is idle, so a new request
// is taken only once the previous one has left the sequencer.
// the result sits in an output register; the next request is accepted while
// it waits, and a stalled receiver holds the finished result in the
// sequencer until the output register frees up.
// reset empties the output, returns to idle, and loads a 200 MHz core clock
// with scheme 0.
module spi_clock_prescaler_select
	import spi_cps_pkg::*;
#(
	parameter int RATE_WIDTH = RATE_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  cfg_reg_t              cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	spi_cps_rate_if.sink          rate_in,
	spi_cps_result_if.source      result_out
);

	localparam int W     = RATE_WIDTH;
	localparam int CNT_W = $clog2(RATE_WIDTH + 1);

	state_t state_q, state_d;

	logic [CFG_DATA_W-1:0] clock_hz_q;
	variant_t              variant_q;

	logic [W-1:0]             divisor_q;
	logic [W-1:0]             quo_q;
	logic [W-1:0]             rem_q;
	logic [CNT_W-1:0]         bit_cnt_q;
	logic [W:0]               pscl_q;
	logic [HALVE_CNT_W-1:0]   halve_cnt_q;
	logic                     zero_q;

	logic [CLOCK_FIELD_W-1:0] field_q;
	logic [PRESCALE_W-1:0]    pres_q;
	logic [PRE_DIV_W-1:0]     pdiv_q;
	logic [SCLK_DIV_W-1:0]    sdiv_q;
	logic                     bad_q;
	logic                     out_valid_q;

	logic         accept;
	logic         out_free;
	logic         load_out;
	logic [W:0]   shifted;
	logic [W+1:0] sub;
	logic         sub_ok;
	logic [W+1:0] pscl_inc;
	logic [W:0]   halved;
	logic         halve_go;
	logic [W:0]   rounded;

	logic [CLOCK_FIELD_W-1:0] fin_field;
	logic [PRESCALE_W-1:0]    fin_pres;
	logic [PRE_DIV_W-1:0]     fin_pdiv;
	logic [SCLK_DIV_W-1:0]    fin_sdiv;
	logic                     fin_bad;

	assign accept   = rate_in.valid && rate_in.ready;
	assign out_free = !out_valid_q || result_out.ready;

	// shared divider step
	assign shifted = {rem_q, quo_q[W-1]};
	assign sub     = {1'b0, shifted} - {2'b00, divisor_q};
	assign sub_ok  = !sub[W+1];

	// shared incrementer and shifter for rounding and halving
	assign pscl_inc = {1'b0, pscl_q} + (W+2)'(1);
	assign halved   = (variant_q == VAR_CEIL) ? pscl_inc[W+1:1] : {1'b0, pscl_q[W:1]};
	assign rounded  = {pscl_inc[W:1], 1'b0};

	always_comb begin
		halve_go = 1'b0;
		case (variant_q) inside
			VAR_CEIL, VAR_FLOOR: halve_go = (pscl_q > (W+1)'(PSCL_MAX))
				&& (halve_cnt_q <= HALVE_CNT_W'(PRE_DIV_MAX));
			VAR_SCLK: halve_go = (pscl_q > (W+1)'(PSCL_MAX_X2))
				&& (halve_cnt_q <= HALVE_CNT_W'(SCLK_DIV_MAX));
			default: halve_go = 1'b0;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		rate_in.ready = 1'b0;
		load_out      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				rate_in.ready = 1'b1;
				if (rate_in.valid) begin
					state_d = (rate_in.bit_rate[W-1:0] == '0) ? ST_FINISH : ST_DIV;
				end
			end
			ST_DIV: begin
				if (bit_cnt_q == CNT_W'(1)) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: state_d = ST_HALVE;
			ST_HALVE: begin
				if (!halve_go) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_hz_q <= CFG_DATA_W'(CLOCK_RESET_HZ);
			variant_q  <= VAR_EVEN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INPUT_CLOCK: clock_hz_q <= cfg_wdata;
				REG_VARIANT:     variant_q  <= variant_t'(cfg_wdata[1:0]);
				default: ;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					divisor_q   <= rate_in.bit_rate[W-1:0];
					quo_q       <= clock_hz_q[W-1:0];
					rem_q       <= '0;
					bit_cnt_q   <= CNT_W'(W);
					halve_cnt_q <= '0;
					zero_q      <= (rate_in.bit_rate[W-1:0] == '0);
				end
			end
			ST_DIV: begin
				rem_q     <= sub_ok ? sub[W-1:0] : shifted[W-1:0];
				quo_q     <= {quo_q[W-2:0], sub_ok};
				bit_cnt_q <= bit_cnt_q - CNT_W'(1);
			end
			ST_HALVE: begin
				if (halve_go) begin
					halve_cnt_q <= halve_cnt_q + HALVE_CNT_W'(1);
				end
			end
			default: ;
		endcase
		if (state_q == ST_DIV && bit_cnt_q == CNT_W'(1)) begin
			// ceiling of the quotient from the final remainder
			pscl_q <= {1'b0, quo_q[W-2:0], sub_ok}
				+ (W+1)'((sub_ok ? sub[W-1:0] : shifted[W-1:0]) != '0);
		end else if (state_q == ST_ROUND) begin
			if (variant_q == VAR_EVEN
				|| (variant_q == VAR_SCLK && pscl_q > (W+1)'(PSCL_MAX))) begin
				pscl_q <= rounded;
			end
		end else if (state_q == ST_HALVE && halve_go) begin
			pscl_q <= halved;
		end
	end

	// result selection
	always_comb begin
		fin_bad   = 1'b0;
		fin_field = '0;
		fin_pres  = '0;
		fin_pdiv  = '0;
		fin_sdiv  = '0;
		unique case (variant_q) inside
			VAR_EVEN: begin
				fin_bad   = pscl_q > (W+1)'(PSCL_MAX_X2);
				fin_pres  = pscl_q[4:1];
				fin_field = X2_BIT | CLOCK_FIELD_W'(fin_pres);
			end
			VAR_CEIL, VAR_FLOOR: begin
				fin_bad   = (pscl_q > (W+1)'(PSCL_MAX))
					|| (halve_cnt_q > HALVE_CNT_W'(PRE_DIV_MAX));
				fin_pres  = pscl_q[3:0];
				fin_pdiv  = halve_cnt_q[PRE_DIV_W-1:0];
				fin_field = pre_bits(fin_pdiv) | CLOCK_FIELD_W'(fin_pres);
			end
			VAR_SCLK: begin
				fin_bad  = (pscl_q > (W+1)'(PSCL_MAX_X2))
					|| (halve_cnt_q > HALVE_CNT_W'(SCLK_DIV_MAX));
				fin_sdiv = halve_cnt_q[SCLK_DIV_W-1:0];
				if (pscl_q > (W+1)'(PSCL_MAX)) begin
					fin_pres  = pscl_q[4:1];
					fin_field = (CLOCK_FIELD_W'(fin_sdiv) << SCLK_DIV_SHIFT) | X2_BIT
						| CLOCK_FIELD_W'(fin_pres);
				end else begin
					fin_pres  = pscl_q[3:0];
					fin_field = (CLOCK_FIELD_W'(fin_sdiv) << SCLK_DIV_SHIFT)
						| CLOCK_FIELD_W'(fin_pres);
				end
			end
			default: fin_bad = 1'b1;
		endcase
		if (zero_q || fin_bad) begin
			fin_bad   = 1'b1;
			fin_field = '0;
			fin_pres  = '0;
			fin_pdiv  = '0;
			fin_sdiv  = '0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			field_q <= fin_field;
			pres_q  <= fin_pres;
			pdiv_q  <= fin_pdiv;
			sdiv_q  <= fin_sdiv;
			bad_q   <= fin_bad;
		end
	end

	assign result_out.valid        = out_valid_q;
	assign result_out.clock_field  = field_q;
	assign result_out.prescale     = pres_q;
	assign result_out.pre_divider  = pdiv_q;
	assign result_out.sclk_divider = sdiv_q;
	assign result_out.rejected     = bad_q;

endmodule
